/* sv/pit_pkg.sv */
// shared types, codes and helpers for the interval timer
package pit_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLOCK = 2'd2,
        FUNC_GATE  = 2'd3
    } t_func;

    localparam logic [1:0] PORT_CTRL = 2'd3;
    localparam logic [1:0] SEL_READBACK = 2'd3;

    localparam logic [1:0] AM_LOW  = 2'd1;
    localparam logic [1:0] AM_HIGH = 2'd2;

    // access flag bit positions
    localparam int AF_LATCHED = 0;
    localparam int AF_RLOW    = 1;
    localparam int AF_RHIGH   = 2;
    localparam int AF_WLOW    = 3;
    localparam int AF_WHIGH   = 4;

    localparam logic [16:0] CNT_FULL  = 17'h10000;
    localparam logic [16:0] CNT_SQ_1  = 17'h10001;
    localparam logic [7:0]  CTRL_INIT = 8'h34;
    localparam logic [7:0]  NO_BYTE   = 8'hFF;

    typedef struct packed {
        logic [16:0] cnt;
        logic [15:0] reload;
        logic [7:0]  ctrl;
        logic [2:0]  mode;
        logic [15:0] latched;
        logic        out;
        logic        gate;
        logic        clk_prev;
        logic [4:0]  af;
        logic        load_pend;
        logic        running;
        logic        nullc;
        logic        st_pend;
        logic [7:0]  st_byte;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{
        cnt: CNT_FULL, reload: 16'h0, ctrl: CTRL_INIT, mode: 3'd3, latched: 16'h0,
        out: 1'b1, gate: 1'b1, clk_prev: 1'b0, af: 5'h0, load_pend: 1'b0,
        running: 1'b0, nullc: 1'b1, st_pend: 1'b0, st_byte: 8'h0};

    // modes 6 and 7 alias 2 and 3
    function automatic logic [2:0] f_mode_map(logic [2:0] code);
        logic [2:0] m;
        begin
            m = code;
            if (code == 3'd6) m = 3'd2;
            if (code == 3'd7) m = 3'd3;
            return m;
        end
    endfunction

endpackage

/* sv/programmable_interval_timer.sv */
// top level of the interval timer: request register, channels, result register
//
// Usage: requests enter on i_in_valid/o_in_ready with i_func, i_port_or_channel,
// i_write_byte and i_line_level. Each request gives exactly one result on
// o_out_valid/i_out_ready: o_read_byte (255 unless a counter read) and
// o_out_levels, the OUT pins after the request has been applied.
// An accepted request waits in the request register; the channel update then
// writes channel state and the result register together, and o_out_valid rises
// from the result register. Throughput is one request per cycle while the
// receiver does not stall; state written by one request is seen by the next.
// When the receiver stalls, the result register holds and the request register
// takes one more request, then o_in_ready drops until the result is taken.
// i_cfg_we writes i_cfg_data into the read-back enable bit at once.
// Reset (i_rst_n low, synchronous) empties both registers, sets every channel
// to mode 3 with OUT high and null count set, and enables read-back.
module programmable_interval_timer #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [1:0] i_port_or_channel,
    input  logic [7:0] i_write_byte,
    input  logic       i_line_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_byte,
    output logic [2:0] o_out_levels,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    logic       r_rb_en;
    logic       r_in_v;
    logic [1:0] r_func;
    logic [1:0] r_pc;
    logic [7:0] r_wb;
    logic       r_lvl;
    logic       r_out_v;
    logic [7:0] r_rd;
    logic [2:0] r_lv;

    logic       out_free;
    logic       go;
    logic [7:0] w_rd [3];
    logic [2:0] w_lv;
    logic [7:0] n_rd;

    assign out_free   = !r_out_v || i_out_ready;
    assign go         = r_in_v && out_free;
    assign o_in_ready = !r_in_v || out_free;

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        if (ch < NUM_CHANNELS) begin : g_on
            pit_chan #(.CH(ch)) u_chan (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_go     (go),
                .i_rb_en  (r_rb_en),
                .i_func   (r_func),
                .i_pc     (r_pc),
                .i_wb     (r_wb),
                .i_lvl    (r_lvl),
                .o_rd     (w_rd[ch]),
                .o_out_nxt(w_lv[ch])
            );
        end else begin : g_off
            assign w_rd[ch] = pit_pkg::NO_BYTE;
            assign w_lv[ch] = 1'b0;
        end
    end

    // only the addressed channel drives a byte other than 255
    assign n_rd = w_rd[0] & w_rd[1] & w_rd[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_en <= 1'b1;
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) r_rb_en <= i_cfg_data;
            if (o_in_ready) r_in_v <= i_in_valid;
            if (out_free) r_out_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func <= i_func;
            r_pc   <= i_port_or_channel;
            r_wb   <= i_write_byte;
            r_lvl  <= i_line_level;
        end
        if (go) begin
            r_rd <= n_rd;
            r_lv <= w_lv;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_read_byte  = r_rd;
    assign o_out_levels = r_lv;

endmodule

/* sv/pit_chan.sv */
// one counter channel: state registers and the per-request update
module pit_chan #(
    parameter int CH = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic       i_rb_en,
    input  logic [1:0] i_func,
    input  logic [1:0] i_pc,
    input  logic [7:0] i_wb,
    input  logic       i_lvl,
    output logic [7:0] o_rd,
    output logic       o_out_nxt
);

    pit_pkg::t_chan_state r_st, n_st;

    function automatic logic [16:0] f_start(pit_pkg::t_chan_state s);
        logic [16:0] v;
        begin
            if (s.reload == 16'h0) v = pit_pkg::CNT_FULL;
            else if (s.mode == 3'd3 && s.reload == 16'h1) v = pit_pkg::CNT_SQ_1;
            else v = {1'b0, s.reload};
            return v;
        end
    endfunction

    function automatic pit_pkg::t_chan_state f_latch(pit_pkg::t_chan_state s);
        pit_pkg::t_chan_state t;
        begin
            t = s;
            t.latched = s.cnt[15:0];
            t.af[pit_pkg::AF_LATCHED] = 1'b1;
            if (s.ctrl[5:4] == pit_pkg::AM_LOW) begin
                t.af[pit_pkg::AF_RLOW]  = 1'b1;
                t.af[pit_pkg::AF_RHIGH] = 1'b0;
            end else if (s.ctrl[5:4] == pit_pkg::AM_HIGH) begin
                t.af[pit_pkg::AF_RLOW]  = 1'b0;
                t.af[pit_pkg::AF_RHIGH] = 1'b1;
            end else begin
                t.af[pit_pkg::AF_RLOW]  = 1'b1;
                t.af[pit_pkg::AF_RHIGH] = 1'b1;
            end
            return t;
        end
    endfunction

    function automatic pit_pkg::t_chan_state f_try_start(pit_pkg::t_chan_state s);
        pit_pkg::t_chan_state t;
        begin
            t = s;
            if (!s.af[pit_pkg::AF_WLOW] && !s.af[pit_pkg::AF_WHIGH] && s.gate)
                t.running = 1'b1;
            return t;
        end
    endfunction

    function automatic logic f_out_upd(logic o, logic [2:0] m, logic [16:0] c,
                                       logic [16:0] tmp);
        logic r;
        begin
            r = o;
            if (m == 3'd3) begin
                r = (c > (tmp >> 1));
            end else begin
                if (c <= 17'd1 && (m == 3'd2 || m == 3'd4 || m == 3'd5)) r = 1'b0;
                if (c == 17'd0) r = 1'b1;
            end
            return r;
        end
    endfunction

    // falling clock edge: at most one reload wrap per step
    function automatic pit_pkg::t_chan_state f_edge(pit_pkg::t_chan_state s);
        pit_pkg::t_chan_state t;
        logic [16:0] c;
        logic [16:0] tmp;
        logic        dec;
        begin
            t = s;
            dec = 1'b1;
            if (s.running) begin
                if (s.load_pend) begin
                    dec = 1'b0;
                    t.load_pend = 1'b0;
                    t.cnt = f_start(s);
                    t.nullc = 1'b0;
                end
                c = t.cnt - {16'h0, dec};
                tmp = f_start(s);
                t.out = f_out_upd(t.out, s.mode, c, tmp);
                if (c == 17'd0) begin
                    if (s.mode == 3'd0 || s.mode == 3'd2 || s.mode == 3'd3) begin
                        c = c + tmp;
                        t.nullc = 1'b0;
                        t.out = f_out_upd(t.out, s.mode, c, tmp);
                    end else begin
                        t.running = 1'b0;
                        c = pit_pkg::CNT_FULL;
                    end
                end
                t.cnt = c;
            end
            return t;
        end
    endfunction

    always_comb begin
        n_st = r_st;
        o_rd = pit_pkg::NO_BYTE;
        unique case (pit_pkg::t_func'(i_func))
            pit_pkg::FUNC_WRITE: begin
                if (i_pc == pit_pkg::PORT_CTRL) begin
                    if (i_wb[7:6] == pit_pkg::SEL_READBACK) begin
                        if (i_rb_en && i_wb[CH+1]) begin
                            if (!i_wb[4] && !r_st.st_pend) begin
                                n_st.st_byte = {r_st.out, r_st.nullc, r_st.ctrl[5:0]};
                                n_st.st_pend = 1'b1;
                            end
                            if (!i_wb[5] && !r_st.af[pit_pkg::AF_LATCHED])
                                n_st = f_latch(n_st);
                        end
                    end else if (i_wb[7:6] == 2'(CH)) begin
                        if (i_wb[5:4] != 2'd0) begin
                            n_st.mode = pit_pkg::f_mode_map(i_wb[3:1]);
                            n_st.af = 5'h0;
                            n_st.ctrl = i_wb;
                            n_st.out = (n_st.mode != 3'd0);
                            n_st.running = 1'b0;
                            n_st.reload = 16'h0;
                            n_st.nullc = 1'b1;
                        end else if (!r_st.af[pit_pkg::AF_LATCHED]) begin
                            n_st = f_latch(r_st);
                        end
                    end
                end else if (i_pc == 2'(CH)) begin
                    if (!r_st.af[pit_pkg::AF_WLOW] && !r_st.af[pit_pkg::AF_WHIGH]) begin
                        n_st.af[pit_pkg::AF_WLOW]  = r_st.ctrl[4];
                        n_st.af[pit_pkg::AF_WHIGH] = r_st.ctrl[5];
                    end
                    if (n_st.af[pit_pkg::AF_WLOW]) begin
                        n_st.reload = {8'h0, i_wb};
                        n_st.af[pit_pkg::AF_WLOW] = 1'b0;
                    end else if (n_st.af[pit_pkg::AF_WHIGH]) begin
                        if (r_st.ctrl[5:4] == pit_pkg::AM_HIGH) n_st.reload = {i_wb, 8'h0};
                        else n_st.reload = {i_wb, r_st.reload[7:0]};
                        n_st.af[pit_pkg::AF_WHIGH] = 1'b0;
                    end
                    n_st.nullc = 1'b1;
                    n_st.out = (r_st.mode != 3'd0);
                    if (r_st.mode == 3'd0 || r_st.mode == 3'd4) begin
                        n_st.running = 1'b0;
                        n_st.load_pend = 1'b1;
                        n_st = f_try_start(n_st);
                    end else if ((r_st.mode == 3'd2 || r_st.mode == 3'd3) && !r_st.running) begin
                        n_st.load_pend = 1'b1;
                        n_st = f_try_start(n_st);
                    end
                end
            end
            pit_pkg::FUNC_READ: begin
                if (i_pc == 2'(CH)) begin
                    if (r_st.st_pend) begin
                        n_st.st_pend = 1'b0;
                        o_rd = r_st.st_byte;
                    end else begin
                        if (r_st.af[2:0] == 3'b000) n_st = f_latch(r_st);
                        if (n_st.af[pit_pkg::AF_RLOW]) begin
                            n_st.af[pit_pkg::AF_RLOW] = 1'b0;
                            if (!n_st.af[pit_pkg::AF_RHIGH]) n_st.af[pit_pkg::AF_LATCHED] = 1'b0;
                            o_rd = n_st.latched[7:0];
                        end else if (n_st.af[pit_pkg::AF_RHIGH]) begin
                            n_st.af[pit_pkg::AF_RHIGH]   = 1'b0;
                            n_st.af[pit_pkg::AF_LATCHED] = 1'b0;
                            o_rd = n_st.latched[15:8];
                        end
                    end
                end
            end
            pit_pkg::FUNC_CLOCK: begin
                if (i_pc == 2'(CH)) begin
                    if (r_st.clk_prev && !i_lvl) n_st = f_edge(r_st);
                    n_st.clk_prev = i_lvl;
                end
            end
            pit_pkg::FUNC_GATE: begin
                if (i_pc == 2'(CH)) begin
                    n_st.gate = i_lvl;
                    if (r_st.gate && !i_lvl) begin
                        if (!(r_st.mode == 3'd1 || r_st.mode == 3'd5)) n_st.running = 1'b0;
                        if (r_st.mode == 3'd2 || r_st.mode == 3'd3) n_st.out = 1'b1;
                    end else if (!r_st.gate && i_lvl) begin
                        n_st.running = 1'b0;
                        if (!(r_st.mode == 3'd0 || r_st.mode == 3'd4)) n_st.load_pend = 1'b1;
                        n_st = f_try_start(n_st);
                        if (r_st.mode == 3'd1) n_st.out = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_out_nxt = n_st.out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pit_pkg::CHAN_RESET;
        end else if (i_go) begin
            r_st <= n_st;
        end
    end

endmodule

/* sv/pit_checker.sv */
// port-level checks for the interval timer, bound to the top level
module pit_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_func,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_byte
);

    // a held result keeps its byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_byte))
        else $error("result changed while stalled");

    // requests are refused only behind a stalled result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request refused without a stall");

    // reset leaves no result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a request other than a read returns the empty byte once it leaves the request register
    a_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_func != pit_pkg::FUNC_READ)
        ##1 (!o_out_valid || i_out_ready) |=> o_out_valid && o_read_byte == pit_pkg::NO_BYTE)
        else $error("non-read request returned a byte");

endmodule

bind programmable_interval_timer pit_checker u_pit_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_func     (i_func),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_read_byte(o_read_byte)
);

/* test/programmable_interval_timer_tb.sv */
// self-checking testbench for the three-channel programmable interval timer
module programmable_interval_timer_tb;

    localparam int NCH = 3;
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        logic [1:0] func;
        logic [1:0] pc;
        logic [7:0] wb;
        logic       lvl;
        int         want_byte;  // -1 when the predictor decides
    } t_row;

    typedef struct {
        logic [7:0] rb;
        logic [2:0] lv;
    } t_res;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_func;
    logic [1:0] i_port_or_channel;
    logic [7:0] i_write_byte;
    logic       i_line_level;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_read_byte;
    logic [2:0] o_out_levels;
    logic       i_cfg_we;
    logic       i_cfg_data;

    programmable_interval_timer #(.NUM_CHANNELS(NCH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_func(i_func), .i_port_or_channel(i_port_or_channel),
        .i_write_byte(i_write_byte), .i_line_level(i_line_level),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_read_byte(o_read_byte), .o_out_levels(o_out_levels),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // predicted timer state
    logic        rb_en;
    logic [16:0] p_cnt [NCH];
    logic [15:0] p_reload [NCH];
    logic [7:0]  p_ctrl [NCH];
    logic [2:0]  p_mode [NCH];
    logic [15:0] p_latch [NCH];
    logic        p_out [NCH];
    logic        p_gate [NCH];
    logic        p_clkp [NCH];
    logic [4:0]  p_af [NCH];
    logic        p_loadp [NCH];
    logic        p_run [NCH];
    logic        p_null [NCH];
    logic        p_stp [NCH];
    logic [7:0]  p_stb [NCH];

    t_res pending_results[$];
    int   fail_count;
    int   cycle_count;
    int   req_count;
    t_row rows[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    task automatic timer_reset_model();
        rb_en = 1'b1;
        for (int c = 0; c < NCH; c++) begin
            p_cnt[c] = pit_pkg::CNT_FULL; p_reload[c] = '0; p_ctrl[c] = pit_pkg::CTRL_INIT;
            p_mode[c] = 3'd3; p_latch[c] = '0; p_out[c] = 1'b1; p_gate[c] = 1'b1;
            p_clkp[c] = 1'b0; p_af[c] = '0; p_loadp[c] = 1'b0; p_run[c] = 1'b0;
            p_null[c] = 1'b1; p_stp[c] = 1'b0; p_stb[c] = '0;
        end
    endtask

    function automatic int reload_start(int c);
        if (p_reload[c] == 0) return 32'h10000;
        if (p_mode[c] == 3 && p_reload[c] == 1) return 32'h10001;
        return int'(p_reload[c]);
    endfunction

    function automatic void arm_counter(int c);
        if (p_af[c][pit_pkg::AF_WLOW] || p_af[c][pit_pkg::AF_WHIGH]) return;
        if (!p_gate[c]) return;
        p_run[c] = 1'b1;
    endfunction

    function automatic void snap_count(int c);
        logic [1:0] am;
        am = p_ctrl[c][5:4];
        p_latch[c] = p_cnt[c][15:0];
        p_af[c][pit_pkg::AF_RLOW] = 1'b0;
        p_af[c][pit_pkg::AF_RHIGH] = 1'b0;
        p_af[c][pit_pkg::AF_LATCHED] = 1'b1;
        if (am == pit_pkg::AM_LOW) p_af[c][pit_pkg::AF_RLOW] = 1'b1;
        else if (am == pit_pkg::AM_HIGH) p_af[c][pit_pkg::AF_RHIGH] = 1'b1;
        else begin
            p_af[c][pit_pkg::AF_RLOW] = 1'b1;
            p_af[c][pit_pkg::AF_RHIGH] = 1'b1;
        end
    endfunction

    function automatic void falling_edge(int c);
        int cnt, full, dec;
        logic [2:0] m;
        dec = 1;
        m = p_mode[c];
        if (!p_run[c]) return;
        if (p_loadp[c]) begin
            dec = 0;
            p_loadp[c] = 1'b0;
            p_cnt[c] = 17'(reload_start(c));
            p_null[c] = 1'b0;
        end
        cnt = int'(p_cnt[c]) - dec;
        full = reload_start(c);
        forever begin
            if (m == 3) p_out[c] = cnt > (full >>> 1);
            else begin
                if (cnt <= 1 && (m == 2 || m == 4 || m == 5)) p_out[c] = 1'b0;
                if (cnt <= 0) p_out[c] = 1'b1;
            end
            if (cnt > 0) break;
            if (m == 0 || m == 2 || m == 3) begin
                cnt += full;
                p_null[c] = 1'b0;
            end else begin
                p_run[c] = 1'b0;
                cnt = 32'h10000;
                break;
            end
        end
        p_cnt[c] = 17'(cnt);
    endfunction

    function automatic void gate_update(int c, logic lvl);
        logic prev;
        logic [2:0] m;
        prev = p_gate[c];
        m = p_mode[c];
        p_gate[c] = lvl;
        if (prev && !lvl) begin
            if (!(m == 1 || m == 5)) p_run[c] = 1'b0;
            if (m == 2 || m == 3) p_out[c] = 1'b1;
        end else if (!prev && lvl) begin
            p_run[c] = 1'b0;
            if (!(m == 0 || m == 4)) p_loadp[c] = 1'b1;
            arm_counter(c);
            if (m == 1) p_out[c] = 1'b0;
        end
    endfunction

    function automatic void count_write(int c, logic [7:0] d);
        logic [2:0] m;
        if (!(p_af[c][pit_pkg::AF_WLOW] || p_af[c][pit_pkg::AF_WHIGH])) begin
            if (p_ctrl[c][4]) p_af[c][pit_pkg::AF_WLOW] = 1'b1;
            if (p_ctrl[c][5]) p_af[c][pit_pkg::AF_WHIGH] = 1'b1;
        end
        if (p_af[c][pit_pkg::AF_WLOW]) begin
            p_reload[c] = {8'h0, d};
            p_af[c][pit_pkg::AF_WLOW] = 1'b0;
        end else if (p_af[c][pit_pkg::AF_WHIGH]) begin
            if (p_ctrl[c][5:4] == pit_pkg::AM_HIGH) p_reload[c] = {d, 8'h0};
            else p_reload[c] = {d, p_reload[c][7:0]};
            p_af[c][pit_pkg::AF_WHIGH] = 1'b0;
        end
        p_null[c] = 1'b1;
        m = p_mode[c];
        p_out[c] = (m != 0);
        if (m == 0 || m == 4) begin
            p_run[c] = 1'b0;
            p_loadp[c] = 1'b1;
            arm_counter(c);
        end else if ((m == 2 || m == 3) && !p_run[c]) begin
            p_loadp[c] = 1'b1;
            arm_counter(c);
        end
    endfunction

    function automatic void control_write(logic [7:0] d);
        int c;
        c = d[7:6];
        if (d[7:6] == pit_pkg::SEL_READBACK) begin
            if (!rb_en) return;
            for (int k = 0; k < NCH; k++) begin
                if (!d[k+1]) continue;
                if (!d[4] && !p_stp[k]) begin
                    p_stb[k] = {p_out[k], p_null[k], p_ctrl[k][5:0]};
                    p_stp[k] = 1'b1;
                end
                if (!d[5] && !p_af[k][pit_pkg::AF_LATCHED]) snap_count(k);
            end
            return;
        end
        if (c >= NCH) return;
        if (d[5:4] != 2'd0) begin
            p_mode[c] = pit_pkg::f_mode_map(d[3:1]);
            p_af[c] = '0;
            p_ctrl[c] = d;
            p_out[c] = (p_mode[c] != 0);
            p_run[c] = 1'b0;
            p_reload[c] = '0;
            p_null[c] = 1'b1;
        end else if (!p_af[c][pit_pkg::AF_LATCHED]) begin
            snap_count(c);
        end
    endfunction

    function automatic logic [7:0] count_read(int c);
        if (p_stp[c]) begin
            p_stp[c] = 1'b0;
            return p_stb[c];
        end
        if (!(p_af[c][pit_pkg::AF_LATCHED] || p_af[c][pit_pkg::AF_RLOW] ||
              p_af[c][pit_pkg::AF_RHIGH]))
            snap_count(c);
        if (p_af[c][pit_pkg::AF_RLOW]) begin
            p_af[c][pit_pkg::AF_RLOW] = 1'b0;
            if (!p_af[c][pit_pkg::AF_RHIGH]) p_af[c][pit_pkg::AF_LATCHED] = 1'b0;
            return p_latch[c][7:0];
        end
        if (p_af[c][pit_pkg::AF_RHIGH]) begin
            p_af[c][pit_pkg::AF_RHIGH] = 1'b0;
            p_af[c][pit_pkg::AF_LATCHED] = 1'b0;
            return p_latch[c][15:8];
        end
        return pit_pkg::NO_BYTE;
    endfunction

    function automatic t_res timer_predict(t_row r);
        t_res res;
        int c;
        c = r.pc;
        res.rb = pit_pkg::NO_BYTE;
        case (pit_pkg::t_func'(r.func))
            pit_pkg::FUNC_WRITE: begin
                if (r.pc == pit_pkg::PORT_CTRL) control_write(r.wb);
                else if (c < NCH) count_write(c, r.wb);
            end
            pit_pkg::FUNC_READ: begin
                if (r.pc != pit_pkg::PORT_CTRL && c < NCH) res.rb = count_read(c);
            end
            pit_pkg::FUNC_CLOCK: begin
                if (r.pc != pit_pkg::PORT_CTRL && c < NCH) begin
                    if (p_clkp[c] && !r.lvl) falling_edge(c);
                    p_clkp[c] = r.lvl;
                end
            end
            default: begin
                if (r.pc != pit_pkg::PORT_CTRL && c < NCH) gate_update(c, r.lvl);
            end
        endcase
        res.lv = '0;
        for (int k = 0; k < NCH; k++) res.lv[k] = p_out[k];
        return res;
    endfunction

    function automatic t_row mk(logic [1:0] f, logic [1:0] pc, logic [7:0] wb,
                                logic lvl, int want);
        t_row r;
        r.func = f; r.pc = pc; r.wb = wb; r.lvl = lvl; r.want_byte = want;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, compare with oldest prediction
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_read_byte, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_read_byte !== want.rb)
                        report_mismatch("read_byte", o_read_byte, want.rb);
                    if (o_out_levels !== want.lv)
                        report_mismatch("out_levels", o_out_levels, want.lv);
                end
            end
            if ($urandom_range(0, 99) < 8) i_out_ready <= 1'b0;
            else if ($urandom_range(0, 99) < 3) i_out_ready <= ($urandom_range(0, 1) == 1);
            else if (!i_out_ready && $urandom_range(0, 3) == 0) i_out_ready <= 1'b1;
            else if (i_out_ready === 1'b1) i_out_ready <= 1'b1;
        end
    end

    // valid stays high between back-to-back requests
    task automatic send_request(t_row r);
        t_res res;
        int gap;
        if ($urandom_range(0, 9) < 3) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= r.func;
        i_port_or_channel <= r.pc;
        i_write_byte <= r.wb;
        i_line_level <= r.lvl;
        res = timer_predict(r);
        if (r.want_byte >= 0 && res.rb !== 8'(r.want_byte))
            report_mismatch("table byte", res.rb, r.want_byte);
        pending_results.push_back(res);
        req_count++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_and_config(logic en);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= en;
        rb_en = en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed sequences: program, load, clock, read
    task automatic random_burst();
        int c, n;
        logic [7:0] cw;
        c = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                cw = {2'(c), 2'($urandom_range(1, 3)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1))};
                send_request(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, cw, 1'b0, -1));
                send_request(mk(pit_pkg::FUNC_WRITE, 2'(c),
                                8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 6)),
                                1'b0, -1));
                if (cw[5:4] == 2'd3)
                    send_request(mk(pit_pkg::FUNC_WRITE, 2'(c),
                                    8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0),
                                    1'b0, -1));
            end
            3, 4, 5: begin
                n = $urandom_range(2, 16);
                repeat (n) begin
                    send_request(mk(pit_pkg::FUNC_CLOCK, 2'(c), 8'($urandom), 1'b1, -1));
                    send_request(mk(pit_pkg::FUNC_CLOCK, 2'(c), 8'($urandom), 1'b0, -1));
                end
            end
            6: send_request(mk(pit_pkg::FUNC_GATE, 2'(c), 8'($urandom), 1'($urandom), -1));
            7: send_request(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'($urandom), 1'b0, -1));
            8: repeat ($urandom_range(1, 3))
                send_request(mk(pit_pkg::FUNC_READ, 2'(c), 8'($urandom), 1'($urandom), -1));
            default: send_request(mk(2'($urandom), 2'($urandom), 8'($urandom),
                                     1'($urandom), -1));
        endcase
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        req_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = '0;
        i_port_or_channel = '0;
        i_write_byte = '0;
        i_line_level = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 1'b0;
        timer_reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_out_ready <= 1'b1;
        @(posedge i_clk);

        // directed table: missing channel, control read, latch, read-back, status
        rows.push_back(mk(pit_pkg::FUNC_READ, pit_pkg::PORT_CTRL, 8'h00, 1'b0, 255));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd0, 8'h00, 1'b0, 0));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd0, 8'h00, 1'b0, 0));
        rows.push_back(mk(pit_pkg::FUNC_CLOCK, pit_pkg::PORT_CTRL, 8'hFF, 1'b1, 255));
        rows.push_back(mk(pit_pkg::FUNC_GATE, pit_pkg::PORT_CTRL, 8'hFF, 1'b0, 255));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'h30, 1'b0, 255));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, 2'd0, 8'hFF, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, 2'd0, 8'hFF, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'h52, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, 2'd1, 8'h03, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_CLOCK, 2'd1, 8'h00, 1'b1, -1));
        rows.push_back(mk(pit_pkg::FUNC_CLOCK, 2'd1, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_CLOCK, 2'd1, 8'h00, 1'b1, -1));
        rows.push_back(mk(pit_pkg::FUNC_CLOCK, 2'd1, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'h40, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd1, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd1, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'hC4, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd1, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd1, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'hBA, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_GATE, 2'd2, 8'h00, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_GATE, 2'd2, 8'h00, 1'b1, -1));
        rows.push_back(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'hEE, 1'b0, -1));
        rows.push_back(mk(pit_pkg::FUNC_READ, 2'd2, 8'h00, 1'b0, -1));
        foreach (rows[i]) send_request(rows[i]);

        // read-back disabled, status still pending from before
        drain_and_config(1'b0);
        send_request(mk(pit_pkg::FUNC_WRITE, pit_pkg::PORT_CTRL, 8'hCE, 1'b0, 255));
        send_request(mk(pit_pkg::FUNC_READ, 2'd0, 8'h00, 1'b0, -1));

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) drain_and_config(ph[0]);
            while (req_count < (ph + 1) * 385) random_burst();
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
